FILE: src/wsc_pkg.sv
package wsc_pkg;

	localparam int MAX_LEN = 256;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);

	localparam logic [1:0] ORDER_EQ = 2'b00;
	localparam logic [1:0] ORDER_GT = 2'b01;
	localparam logic [1:0] ORDER_LT = 2'b11;

	typedef struct packed {
		logic load;
		logic ptr_clear;
		logic eval_gap;
		logic eval_word;
		logic clear;
	} wsc_cmd_t;

	typedef struct packed {
		logic       last_end;
		logic       finish;
		logic       go_word;
		logic       go_gap;
		logic [1:0] order;
		logic       overflow;
	} wsc_status_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

FILE: src/wsc_datapath.sv
module wsc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  wsc_pkg::wsc_cmd_t   cmd,
	input  logic                string_select,
	input  logic [7:0]          char_code,
	output wsc_pkg::wsc_status_t status
);
	import wsc_pkg::*;

	logic [7:0]       text_a [MAX_LEN];
	logic [7:0]       text_b [MAX_LEN];
	logic [7:0]       data_a_q, data_b_q;
	logic [LEN_W-1:0] length_a_q, length_b_q;
	logic [LEN_W-1:0] ptr_a_q, ptr_b_q;
	logic             ended_a_q, ended_b_q, overflow_q;

	logic             sel_ended, other_ended, is_zero, room, store_a, store_b;
	logic [LEN_W-1:0] sel_len;
	logic             a_in, b_in, a_let, b_let, skip_a, skip_b;
	logic             gap_finish, word_finish, word_advance;
	logic [1:0]       gap_order, word_order;

	assign sel_ended   = string_select ? ended_b_q : ended_a_q;
	assign other_ended = string_select ? ended_a_q : ended_b_q;
	assign sel_len     = string_select ? length_b_q : length_a_q;
	assign is_zero     = (char_code == 8'd0);
	assign room        = (sel_len < LEN_W'(MAX_LEN));
	assign store_a     = cmd.load && !string_select && !ended_a_q && !is_zero && room;
	assign store_b     = cmd.load && string_select && !ended_b_q && !is_zero && room;

	// Buffers: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (store_a) begin
			text_a[length_a_q[ADDR_W-1:0]] <= char_code;
		end
		if (store_b) begin
			text_b[length_b_q[ADDR_W-1:0]] <= char_code;
		end
		data_a_q <= text_a[ptr_a_q[ADDR_W-1:0]];
		data_b_q <= text_b[ptr_b_q[ADDR_W-1:0]];
	end

	assign a_in   = (ptr_a_q < length_a_q);
	assign b_in   = (ptr_b_q < length_b_q);
	assign a_let  = a_in && is_letter(data_a_q);
	assign b_let  = b_in && is_letter(data_b_q);
	assign skip_a = a_in && !a_let;
	assign skip_b = b_in && !b_let;

	// Gap phase: both sides skip separators until each sits on a letter or its end.
	always_comb begin
		gap_finish = 1'b0;
		gap_order  = ORDER_EQ;
		if (!skip_a && !skip_b) begin
			if (!a_in && !b_in) begin
				gap_finish = 1'b1;
				gap_order  = ORDER_EQ;
			end else if (!a_in) begin
				gap_finish = 1'b1;
				gap_order  = ORDER_LT;
			end else if (!b_in) begin
				gap_finish = 1'b1;
				gap_order  = ORDER_GT;
			end
		end
	end

	// Word phase: compare letter by letter while both words continue.
	always_comb begin
		word_finish  = 1'b0;
		word_order   = ORDER_EQ;
		word_advance = 1'b0;
		if (!a_let && !b_let) begin
			word_finish = 1'b0;
		end else if (!a_let) begin
			word_finish = 1'b1;
			word_order  = ORDER_LT;
		end else if (!b_let) begin
			word_finish = 1'b1;
			word_order  = ORDER_GT;
		end else if (data_a_q != data_b_q) begin
			word_finish = 1'b1;
			word_order  = (data_a_q > data_b_q) ? ORDER_GT : ORDER_LT;
		end else begin
			word_advance = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_a_q <= '0;
			length_b_q <= '0;
			ended_a_q  <= 1'b0;
			ended_b_q  <= 1'b0;
			overflow_q <= 1'b0;
			ptr_a_q    <= '0;
			ptr_b_q    <= '0;
		end else begin
			if (cmd.clear) begin
				length_a_q <= '0;
				length_b_q <= '0;
				ended_a_q  <= 1'b0;
				ended_b_q  <= 1'b0;
				overflow_q <= 1'b0;
			end else if (cmd.load && !sel_ended) begin
				if (is_zero) begin
					if (string_select) begin
						ended_b_q <= 1'b1;
					end else begin
						ended_a_q <= 1'b1;
					end
				end else if (!room) begin
					overflow_q <= 1'b1;
				end else if (string_select) begin
					length_b_q <= LEN_W'(length_b_q + 1'b1);
				end else begin
					length_a_q <= LEN_W'(length_a_q + 1'b1);
				end
			end

			if (cmd.ptr_clear) begin
				ptr_a_q <= '0;
				ptr_b_q <= '0;
			end else if (cmd.eval_gap) begin
				if (skip_a) begin
					ptr_a_q <= LEN_W'(ptr_a_q + 1'b1);
				end
				if (skip_b) begin
					ptr_b_q <= LEN_W'(ptr_b_q + 1'b1);
				end
			end else if (cmd.eval_word && word_advance) begin
				ptr_a_q <= LEN_W'(ptr_a_q + 1'b1);
				ptr_b_q <= LEN_W'(ptr_b_q + 1'b1);
			end
		end
	end

	always_comb begin
		status.last_end = cmd.load && is_zero && !sel_ended && other_ended;
		status.finish   = (cmd.eval_gap && gap_finish) || (cmd.eval_word && word_finish);
		status.go_word  = !skip_a && !skip_b && a_in && b_in;
		status.go_gap   = !a_let && !b_let;
		status.order    = cmd.eval_word ? word_order : gap_order;
		status.overflow = overflow_q;
	end

endmodule

FILE: src/wsc_ctrl.sv
module wsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  wsc_pkg::wsc_status_t status,
	output wsc_pkg::wsc_cmd_t    cmd,
	output logic                 busy,
	output logic                 done,
	output logic [1:0]           order,
	output logic                 truncated
);
	import wsc_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_GAP_FETCH,
		ST_GAP_EVAL,
		ST_WORD_FETCH,
		ST_WORD_EVAL
	} state_t;

	state_t     state_q;
	logic       done_q, truncated_q;
	logic [1:0] order_q;

	always_comb begin
		cmd.load      = (state_q == ST_LOAD) && start;
		cmd.ptr_clear = (state_q == ST_LOAD);
		cmd.eval_gap  = (state_q == ST_GAP_EVAL);
		cmd.eval_word = (state_q == ST_WORD_EVAL);
		cmd.clear     = status.finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			done_q      <= 1'b0;
			order_q     <= ORDER_EQ;
			truncated_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (status.finish) begin
				done_q      <= 1'b1;
				order_q     <= status.order;
				truncated_q <= status.overflow;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (status.last_end) begin
						state_q <= ST_GAP_FETCH;
					end
				end
				ST_GAP_FETCH: begin
					state_q <= ST_GAP_EVAL;
				end
				ST_GAP_EVAL: begin
					if (status.finish) begin
						state_q <= ST_LOAD;
					end else if (status.go_word) begin
						state_q <= ST_WORD_FETCH;
					end else begin
						state_q <= ST_GAP_FETCH;
					end
				end
				ST_WORD_FETCH: begin
					state_q <= ST_WORD_EVAL;
				end
				ST_WORD_EVAL: begin
					if (status.finish) begin
						state_q <= ST_LOAD;
					end else if (status.go_gap) begin
						state_q <= ST_GAP_FETCH;
					end else begin
						state_q <= ST_WORD_FETCH;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_LOAD);
	assign done      = done_q;
	assign order     = order_q;
	assign truncated = truncated_q;

endmodule

FILE: src/word_sequence_compare.sv
// Word-by-word string compare. Characters of strings A and B arrive one
// transaction at a time on start/string_select/char_code, one per clock while
// busy is low, in any interleaving; a zero byte ends the selected string.
// Characters beyond 256 per string are dropped and flagged in truncated.
// The transaction that ends the second string starts the compare, and busy
// stays high while it runs. The compare walks both buffers through one
// registered read port each, passing through a fetch state and an evaluate
// state per step; a step advances at least one read pointer or moves between
// the separator-skipping and letter-matching phases. The result appears on
// order and truncated, marked by done for exactly one cycle, in the cycle
// busy falls; the receiver cannot stall it, so it must capture the result
// in that cycle. The block then starts a fresh pair of strings.
module word_sequence_compare (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              string_select,
	input  logic [7:0]        char_code,
	output logic              done,
	output logic signed [1:0] order,
	output logic              truncated
);
	import wsc_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	wsc_cmd_t    cmd;
	wsc_status_t status;
	logic [1:0]  order_raw;

	wsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.order     (order_raw),
		.truncated (truncated)
	);

	// The datapath holds both string buffers, the lengths and end flags, and
	// the two read pointers with the per-step decision logic.
	wsc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.string_select (string_select),
		.char_code     (char_code),
		.status        (status)
	);

	// The order code is 1 for greater, all ones (-1) for less, 0 for equal.
	assign order = signed'(order_raw);

endmodule

FILE: src/wsc_checker.sv
module wsc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic signed [1:0] order
);

	// A result strobe lasts one cycle, and results never come back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// The result is shown as the block becomes free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// A compare only starts on an accepted transaction.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted transaction");

	// No result directly follows an accepted transaction.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result one cycle after a transaction");

	// The order code is never the unused pattern.
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (order != 2'sb10))
		else $error("invalid order code");

endmodule

bind word_sequence_compare wsc_checker u_wsc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.order  (order)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for word_sequence_compare.
//
// Characters of strings A and B are sent one transaction at a time, in a
// random interleaving of the two strings. A scoreboard model inside this module
// mirrors the block. It keeps its own copy of both buffers, their lengths,
// the end-of-string flags and the overflow flag. It works out the result
// that each accepted transaction causes. Every result strobed on done is
// checked field by field against the oldest pending verdict.
//
// Order of tests: a short directed part (orders, separator handling,
// repeated ends and characters after an end), one buffer-full compare, and
// then three random phases. The middle random phase runs with no sender
// gaps. Between phases the sender holds off until every verdict has come
// back.
module tb_top;
	import wsc_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 5;
	// The limit leaves plenty of margin over the longest compare and over the
	// longest sender gap.
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [1:0] order;
		logic       truncated;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              string_select = 1'b0;
	logic [7:0]        char_code = 8'h00;
	logic              busy;
	logic              done;
	logic signed [1:0] order;
	logic              truncated;

	word_sequence_compare uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.string_select(string_select),
		.char_code    (char_code),
		.done         (done),
		.order        (order),
		.truncated    (truncated)
	);

	always #HALF_PERIOD clk = ~clk;

	// Scoreboard copy of the block state.
	bit [7:0]    held_a [MAX_LEN];
	bit [7:0]    held_b [MAX_LEN];
	int unsigned held_len_a = 0;
	int unsigned held_len_b = 0;
	bit          closed_a = 1'b0;
	bit          closed_b = 1'b0;
	bit          dropped_any = 1'b0;

	verdict_t    pending_verdicts[$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned stall_cycles = 0;
	bit          gaps_on = 1'b1;

	// The two strings of the next compare, without their terminating zero.
	bit [7:0] plan_a[$];
	bit [7:0] plan_b[$];

	function automatic bit alpha_byte(input bit [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	// Walks both stored strings word by word. Runs of non-letters only
	// separate words, so they never take part in the ordering.
	function automatic logic [1:0] order_of_words();
		int unsigned pa;
		int unsigned pb;
		bit          wa;
		bit          wb;
		bit          ca;
		bit          cb;
		pa = 0;
		pb = 0;
		while (1) begin
			while (pa < held_len_a && !alpha_byte(held_a[pa]))
				pa++;
			while (pb < held_len_b && !alpha_byte(held_b[pb]))
				pb++;
			wa = pa < held_len_a;
			wb = pb < held_len_b;
			if (!wa && !wb)
				return ORDER_EQ;
			if (!wa)
				return ORDER_LT;
			if (!wb)
				return ORDER_GT;
			while (1) begin
				ca = pa < held_len_a && alpha_byte(held_a[pa]);
				cb = pb < held_len_b && alpha_byte(held_b[pb]);
				if (!ca && !cb)
					break;
				if (!ca)
					return ORDER_LT;
				if (!cb)
					return ORDER_GT;
				if (held_a[pa] != held_b[pb])
					return (held_a[pa] > held_b[pb]) ? ORDER_GT : ORDER_LT;
				pa++;
				pb++;
			end
		end
	endfunction

	// Applies one accepted transaction to the scoreboard copy. When it ends
	// the second string, the verdict is queued and the copy starts afresh.
	function automatic void absorb_char(input bit sel, input bit [7:0] ch);
		verdict_t v;
		if (sel ? closed_b : closed_a)
			return;
		if (ch != 8'h00) begin
			if (sel) begin
				if (held_len_b < MAX_LEN) begin
					held_b[held_len_b] = ch;
					held_len_b++;
				end else begin
					dropped_any = 1'b1;
				end
			end else begin
				if (held_len_a < MAX_LEN) begin
					held_a[held_len_a] = ch;
					held_len_a++;
				end else begin
					dropped_any = 1'b1;
				end
			end
			return;
		end
		if (sel)
			closed_b = 1'b1;
		else
			closed_a = 1'b1;
		if (!(closed_a && closed_b))
			return;
		v.order = order_of_words();
		v.truncated = dropped_any;
		pending_verdicts.push_back(v);
		held_len_a = 0;
		held_len_b = 0;
		closed_a = 1'b0;
		closed_b = 1'b0;
		dropped_any = 1'b0;
	endfunction

	// Sends one character. The task returns in the time step of the edge
	// that accepted it, with start still high, so a following call can keep
	// start high without lowering it in between. While gaps are on, each cycle
	// is idle first with a chance of about one in five, drawn again for every cycle.
	task automatic send_char(input bit sel, input bit [7:0] ch);
		while (gaps_on && $urandom_range(0, 99) < 22) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		string_select <= sel;
		char_code <= ch;
		@(posedge clk);
		// Signals read right after the edge still hold their pre-edge values.
		while (busy)
			@(posedge clk);
		absorb_char(sel, ch);
		items_sent++;
	endtask

	// Holds the sender off until every queued verdict has been checked.
	task automatic wait_for_verdicts();
		start <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Mostly letters from a small set, so that words often match over long
	// stretches. The rest are other letters and every kind of separator.
	function automatic bit [7:0] text_byte();
		int       r;
		bit [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			case ($urandom_range(0, 4))
				0: c = 8'h61;
				1: c = 8'h62;
				2: c = 8'h7A;
				3: c = 8'h41;
				default: c = 8'h5A;
			endcase
		end else if (r < 72) begin
			r = $urandom_range(0, 51);
			c = (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
		end else begin
			do
				c = 8'($urandom_range(1, 255));
			while (alpha_byte(c));
		end
		return c;
	endfunction

	// Builds a pair of strings. B is usually derived from A so that the
	// compare runs deep before it decides.
	task automatic draft_pair();
		int       len;
		int       mode;
		int       pos;
		bit [7:0] swap_q[$];
		len = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 300) : $urandom_range(0, 14);
		plan_a.delete();
		repeat (len) plan_a.push_back(text_byte());
		plan_b = plan_a;
		mode = $urandom_range(0, 99);
		if (mode < 40) begin
			// Identical strings.
		end else if (mode < 60) begin
			if (plan_b.size() != 0) begin
				pos = $urandom_range(0, plan_b.size() - 1);
				plan_b[pos] = text_byte();
			end
		end else if (mode < 72) begin
			if (plan_b.size() != 0) begin
				pos = $urandom_range(0, plan_b.size() - 1);
				while (plan_b.size() > pos)
					void'(plan_b.pop_back());
			end
		end else if (mode < 84) begin
			repeat ($urandom_range(1, 4)) plan_b.push_back(text_byte());
		end else begin
			plan_b.delete();
			repeat ($urandom_range(0, 14)) plan_b.push_back(text_byte());
		end
		if ($urandom_range(0, 1)) begin
			swap_q = plan_a;
			plan_a = plan_b;
			plan_b = swap_q;
		end
	endtask

	// Sends plan_a and plan_b, each with its terminating zero, in a random
	// interleaving. With noise on, stray characters and repeated ends are
	// sent for a string that has ended while the other is still open.
	task automatic run_pair(input bit noise);
		int unsigned ia;
		int unsigned ib;
		int unsigned na;
		int unsigned nb;
		bit          side;
		bit [7:0]    ch;
		ia = 0;
		ib = 0;
		na = plan_a.size() + 1;
		nb = plan_b.size() + 1;
		while (ia < na || ib < nb) begin
			if (ia == na)
				side = 1'b1;
			else if (ib == nb)
				side = 1'b0;
			else
				side = 1'($urandom_range(0, 1));
			if (side) begin
				ch = (ib < plan_b.size()) ? plan_b[ib] : 8'h00;
				ib++;
			end else begin
				ch = (ia < plan_a.size()) ? plan_a[ia] : 8'h00;
				ia++;
			end
			send_char(side, ch);
			if (noise && (side ? (ib == nb && ia < na) : (ia == na && ib < nb))
					&& $urandom_range(0, 99) < 15)
				send_char(side, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
		end
	endtask

	// Letter boundaries, a string with no letters, a word that is a prefix of
	// another, separators of different kinds, and two empty strings.
	task automatic test_word_orders();
		plan_a = {8'h61};
		plan_b = {8'h62};
		run_pair(1'b0);
		plan_a = {8'h5A};
		plan_b = {8'h80, 8'h40};
		run_pair(1'b0);
		plan_a = {8'h61, 8'h62};
		plan_b = {8'h61, 8'h7B};
		run_pair(1'b0);
		plan_a = {8'h41, 8'hFF, 8'h7A};
		plan_b = {8'h41, 8'h5B, 8'h7A, 8'h60};
		run_pair(1'b0);
		plan_a = {};
		plan_b = {};
		run_pair(1'b0);
	endtask

	// A character for a string that has ended is ignored, and so is a second
	// zero for it: neither may produce a result.
	task automatic test_end_handling();
		send_char(1'b0, 8'h7A);
		send_char(1'b0, 8'h00);
		send_char(1'b0, 8'h71);
		send_char(1'b0, 8'h00);
		send_char(1'b1, 8'h7A);
		send_char(1'b1, 8'h00);
	endtask

	// String A gets one letter more than the buffer holds. The dropped letter
	// would decide the order if it were kept, so the compare must come out
	// equal with the truncation flag set.
	task automatic test_buffer_full();
		plan_a.delete();
		for (int i = 0; i < MAX_LEN; i++)
			plan_a.push_back((i % 7 == 6) ? 8'h20 : 8'(8'h61 + i % 5));
		plan_b = plan_a;
		plan_a.push_back(8'h78);
		run_pair(1'b0);
	endtask

	// Random compares with bursts of unrelated transactions mixed in. The
	// bursts may end strings early, which the scoreboard follows as well.
	task automatic test_random_pairs(input int unsigned count, input bit with_gaps);
		int unsigned goal;
		goal = items_sent + count;
		gaps_on = with_gaps;
		while (items_sent < goal) begin
			if ($urandom_range(0, 99) < 10) begin
				repeat ($urandom_range(1, 6))
					send_char(1'($urandom_range(0, 1)),
						($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
			end else begin
				draft_pair();
				run_pair(1'b1);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Each strobed result is checked against the oldest pending verdict.
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: order=%0d truncated=%0b", order, truncated);
				mismatches++;
			end else begin
				v = pending_verdicts.pop_front();
				if (order !== v.order) begin
					$error("order: expected %0d, actual %0d", $signed(v.order), order);
					mismatches++;
				end
				if (truncated !== v.truncated) begin
					$error("truncated: expected %0b, actual %0b", v.truncated, truncated);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transaction is accepted and no
	// result is strobed.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_word_orders();
		test_end_handling();
		wait_for_verdicts();
		test_buffer_full();
		wait_for_verdicts();
		test_random_pairs(220, 1'b1);
		wait_for_verdicts();
		test_random_pairs(160, 1'b0);
		wait_for_verdicts();
		test_random_pairs(220, 1'b1);
		wait_for_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
